>>> hdl/pidaw_pkg.sv
// Package for the anti-windup PID controller: register indexes, widths and reset values.
package pidaw_pkg;

	localparam int GAIN_W = 32;
	localparam int OUT_W  = 16;
	localparam int LIM_W  = 20;
	localparam int THR_W  = 16;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_OUT_LOW       = 3'd3,
		REG_OUT_HIGH      = 3'd4,
		REG_WINDUP_MODE   = 3'd5,
		REG_INTEG_LIMIT   = 3'd6,
		REG_SEP_THRESHOLD = 3'd7
	} reg_idx_t;

	localparam logic signed [OUT_W-1:0] OUT_LOW_RST  = 16'sh8000;
	localparam logic signed [OUT_W-1:0] OUT_HIGH_RST = 16'sh7fff;
	localparam logic [LIM_W-1:0]        INTEG_LIMIT_RST = 20'd19660;

endpackage

>>> hdl/pid_controller_antiwindup.sv
// Top level of the PID controller with integral clamp and back-off anti-windup.

// Each transfer on the input channel carries a setpoint and a measurement and yields exactly
// one transfer on the output channel: the control value drive, clamped to out_low..out_high,
// and a saturated flag. The samples are registered on entry, the full update (error,
// integral with clamp and optional clear on large error, three Q16.16 gain products,
// floor shift, output clamp and integral back-off) is one combinational pass, and the
// result is registered on exit. One item is taken per cycle while the output is not stalled.
// The integrator loop limits throughput, closing through the gain_i product and output clamp
// inside that pass. Configuration registers are written through cfg_we/cfg_index/cfg_data,
// by the user only while no item is in flight; the block does not enforce this.
module pid_controller_antiwindup
	import pidaw_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [IDX_W-1:0]              cfg_index,
	input  logic [DATA_W-1:0]             cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] target,
	input  logic signed [SAMPLE_BITS-1:0] feedback,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_W-1:0]       drive,
	output logic                          saturated
);

	localparam int EW   = SAMPLE_BITS + 1;
	localparam int ESW  = ((LIM_W > SAMPLE_BITS) ? LIM_W : SAMPLE_BITS) + 2;
	localparam int ETW  = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
	localparam int PPW  = GAIN_W + EW;
	localparam int PIW  = GAIN_W + ESW;
	localparam int AW   = PIW + 2;

	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [OUT_W-1:0]  out_low_q, out_high_q;
	logic                     windup_mode_q;
	logic [LIM_W-1:0]         integ_limit_q;
	logic [THR_W-1:0]         sep_threshold_q;

	logic signed [ESW-1:0]         err_sum_q;
	logic signed [SAMPLE_BITS-1:0] prev_feedback_q;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] target_s1, feedback_s1;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] drive_q;
	logic                    sat_q;

	logic                    adv;
	logic                    xfer_s1;
	logic signed [EW-1:0]    err;
	logic signed [EW-1:0]    dmeas;
	logic signed [ETW-1:0]   err_ext, thr_ext;
	logic                    sep_clear;
	logic signed [ESW:0]     lim_ext, sum_raw;
	logic signed [ESW-1:0]   sum_clamp, err_sum_next;
	logic signed [PPW-1:0]   prod_p, prod_d;
	logic signed [PIW-1:0]   prod_i;
	logic signed [AW-1:0]    acc, y, hi_ext, lo_ext;
	logic signed [OUT_W-1:0] drv;
	logic                    sat;

	assign adv      = !out_valid_q || !out_stall;
	assign xfer_s1  = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_comb begin
		err     = EW'(target_s1) - EW'(feedback_s1);
		dmeas   = EW'(feedback_s1) - EW'(prev_feedback_q);
		err_ext = ETW'(err);
		thr_ext = $signed({{(ETW-THR_W){1'b0}}, sep_threshold_q});
		sep_clear = windup_mode_q && ((err_ext > thr_ext) || (err_ext < -thr_ext));

		lim_ext = $signed({{(ESW+1-LIM_W){1'b0}}, integ_limit_q});
		sum_raw = (sep_clear ? '0 : (ESW+1)'(err_sum_q)) + (ESW+1)'(err);
		if (sum_raw > lim_ext) begin
			sum_clamp = ESW'(lim_ext);
		end else if (sum_raw < -lim_ext) begin
			sum_clamp = ESW'(-lim_ext);
		end else begin
			sum_clamp = ESW'(sum_raw);
		end

		prod_p = gain_p_q * err;
		prod_i = gain_i_q * sum_clamp;
		prod_d = gain_d_q * dmeas;
		acc    = AW'(prod_p) + AW'(prod_i) - AW'(prod_d);
		y      = acc >>> FRAC_BITS;

		hi_ext = AW'(out_high_q);
		lo_ext = AW'(out_low_q);
		priority if (y > hi_ext) begin
			drv = out_high_q;
			sat = 1'b1;
		end else if (y < lo_ext) begin
			drv = out_low_q;
			sat = 1'b1;
		end else begin
			drv = OUT_W'(y);
			sat = 1'b0;
		end

		if (sat && !gain_i_q[GAIN_W-1] && (gain_i_q != '0)) begin
			err_sum_next = sum_clamp - ESW'(err);
		end else begin
			err_sum_next = sum_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			out_low_q       <= OUT_LOW_RST;
			out_high_q      <= OUT_HIGH_RST;
			windup_mode_q   <= 1'b0;
			integ_limit_q   <= INTEG_LIMIT_RST;
			sep_threshold_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN_P:        gain_p_q        <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:        gain_i_q        <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:        gain_d_q        <= cfg_data[GAIN_W-1:0];
				REG_OUT_LOW:       out_low_q       <= cfg_data[OUT_W-1:0];
				REG_OUT_HIGH:      out_high_q      <= cfg_data[OUT_W-1:0];
				REG_WINDUP_MODE:   windup_mode_q   <= cfg_data[0];
				REG_INTEG_LIMIT:   integ_limit_q   <= cfg_data[LIM_W-1:0];
				REG_SEP_THRESHOLD: sep_threshold_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			target_s1   <= target;
			feedback_s1 <= feedback;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q       <= '0;
			prev_feedback_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (xfer_s1) begin
				err_sum_q       <= err_sum_next;
				prev_feedback_q <= feedback_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_s1) begin
			drive_q <= drv;
			sat_q   <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

	// stall on entry only while a sample waits behind a held result
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!xfer_s1 |=> ($stable(err_sum_q) && $stable(prev_feedback_q)))
		else $error("controller state changed without a transfer");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_s1 |=> out_valid_q)
		else $error("transfer from input stage produced no result");

	a_prev_meas: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_s1 |=> (prev_feedback_q == $past(feedback_s1)))
		else $error("last measurement not captured");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the anti-windup PID controller.
`timescale 1ns / 100ps

module tb
	import pidaw_pkg::*;
();

	typedef struct {
		logic signed [OUT_W-1:0] drive;
		logic                    sat;
	} pid_out_t;

	class pid_scoreboard;
		logic signed [GAIN_W-1:0] kp, ki, kd;
		logic signed [OUT_W-1:0]  lo_lim, hi_lim;
		logic                     sep_mode;
		logic [LIM_W-1:0]         sum_lim;
		logic [THR_W-1:0]         sep_thr;
		longint                   err_sum, prev_fb;
		pid_out_t                 drive_q[$];
		int                       errors;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			lo_lim = OUT_LOW_RST;
			hi_lim = OUT_HIGH_RST;
			sep_mode = 1'b0;
			sum_lim = INTEG_LIMIT_RST;
			sep_thr = '0;
			err_sum = 0;
			prev_fb = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_GAIN_P:        kp = data;
				REG_GAIN_I:        ki = data;
				REG_GAIN_D:        kd = data;
				REG_OUT_LOW:       lo_lim = data[OUT_W-1:0];
				REG_OUT_HIGH:      hi_lim = data[OUT_W-1:0];
				REG_WINDUP_MODE:   sep_mode = data[0];
				REG_INTEG_LIMIT:   sum_lim = data[LIM_W-1:0];
				REG_SEP_THRESHOLD: sep_thr = data[THR_W-1:0];
				default: ;
			endcase
		endfunction

		// Accepted input transfer: update the integrator and queue the control value.
		function void note_sample(logic signed [15:0] tgt, logic signed [15:0] fb);
			longint   e, mag, lim, acc, y;
			pid_out_t res;
			e = longint'(tgt) - longint'(fb);
			mag = (e < 0) ? -e : e;
			lim = longint'(sum_lim);
			if (sep_mode && mag > longint'(sep_thr))
				err_sum = 0;
			err_sum += e;
			if (err_sum > lim)
				err_sum = lim;
			if (err_sum < -lim)
				err_sum = -lim;
			acc = longint'(kp) * e + longint'(ki) * err_sum
				- longint'(kd) * (longint'(fb) - prev_fb);
			prev_fb = longint'(fb);
			y = acc >>> 16;
			res.sat = 1'b1;
			if (y > longint'(hi_lim))
				res.drive = hi_lim;
			else if (y < longint'(lo_lim))
				res.drive = lo_lim;
			else begin
				res.drive = y[OUT_W-1:0];
				res.sat = 1'b0;
			end
			if (res.sat && ki > 0)
				err_sum -= e;
			drive_q.push_back(res);
		endfunction

		function void check_result(logic signed [OUT_W-1:0] drv, logic sat);
			pid_out_t want;
			if (drive_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got drive %0d saturated %0b",
					$time, drv, sat);
				errors++;
				return;
			end
			want = drive_q.pop_front();
			if (drv !== want.drive) begin
				$display("%0t: drive expected %0d got %0d", $time, want.drive, drv);
				errors++;
			end
			if (sat !== want.sat) begin
				$display("%0t: saturated expected %0b got %0b", $time, want.sat, sat);
				errors++;
			end
		endfunction

		function int pending();
			return drive_q.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [DATA_W-1:0]       cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [15:0]      target = '0;
	logic signed [15:0]      feedback = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [OUT_W-1:0] drive;
	logic                    saturated;

	pid_scoreboard sb;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	bit            hold_req = 1'b0;

	pid_controller_antiwindup uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.target    (target),
		.feedback  (feedback),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive),
		.saturated (saturated)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(target, feedback);
			if (out_valid && !out_stall)
				sb.check_result(drive, saturated);
		end
	end

	// Output side: random stalls plus one long hold-off.
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 300;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Returns at the rising edge where the transfer happened.
	task automatic send_sample(logic signed [15:0] tgt, logic signed [15:0] fb);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		target <= tgt;
		feedback <= fb;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
	endtask

	task automatic configure(logic signed [31:0] p, logic signed [31:0] i,
			logic signed [31:0] d, logic signed [15:0] lo, logic signed [15:0] hi,
			logic mode, logic [19:0] lim, logic [15:0] thr);
		wait_drain();
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_I, i);
		write_reg(REG_GAIN_D, d);
		write_reg(REG_OUT_LOW, {16'd0, lo});
		write_reg(REG_OUT_HIGH, {16'd0, hi});
		write_reg(REG_WINDUP_MODE, {31'd0, mode});
		write_reg(REG_INTEG_LIMIT, {12'd0, lim});
		write_reg(REG_SEP_THRESHOLD, {16'd0, thr});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_gain();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3, 4, 5: return int'($urandom_range(0, 524288)) - 262144;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] corner_sample();
		case ($urandom_range(4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	function automatic int clip16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	initial begin
		logic signed [31:0] kp, ki, kd;
		logic signed [15:0] lo, hi, sp;
		logic [19:0]        lim;
		logic [15:0]        thr;
		int                 fbv, pick;

		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero gains
		send_sample(16'sd1000, -16'sd200);
		send_sample(16'sh8000, 16'sh7fff);

		// threshold edge, separation clear, clamps with back-off
		configure(32'sh0001_0000, 32'sh0000_4000, 32'sh0000_8000, -16'sd1000, 16'sd1000,
			1'b1, 20'd5000, 16'd100);
		send_sample(16'sd100, 16'sd0);
		send_sample(16'sd201, 16'sd100);
		send_sample(16'sd0, 16'sd101);
		send_sample(16'sd50, 16'sd20);
		send_sample(16'sd2000, 16'sd0);
		send_sample(-16'sd2000, 16'sd0);
		send_sample(16'sh7fff, 16'sh8000);
		send_sample(16'sh8000, 16'sh7fff);
		send_sample(16'sd0, 16'sd0);

		// crossed limits, extreme gains, negative integral gain, zero integral limit
		configure(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 16'sd500, -16'sd500,
			1'b0, 20'd0, 16'hffff);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sh7fff, 16'sh8000);
		send_sample(16'sh8000, 16'sh7fff);
		send_sample(16'sd0, 16'sh7fff);
		send_sample(16'sd0, 16'sh8000);

		// widest integral limit, largest threshold: output saturates and the integral is backed off
		configure(32'sd0, 32'sh0001_0000, 32'sd0, 16'sh8000, 16'sh7fff,
			1'b1, 20'hfffff, 16'hffff);
		repeat (4) send_sample(16'sh7fff, 16'sh8000);

		for (int chunk = 0; chunk < 18; chunk++) begin
			tx_idle_pct = (chunk < 6) ? 13 : (chunk < 12) ? 73 : 0;
			rx_idle_pct = (chunk < 6) ? 73 : (chunk < 12) ? 13 : 0;
			kp = pick_gain();
			ki = pick_gain();
			kd = pick_gain();
			case ($urandom_range(7))
				0, 1: begin
					lo = 16'sh8000;
					hi = 16'sh7fff;
				end
				2: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				default: begin
					lo = 16'(-int'($urandom_range(0, 20000)));
					hi = 16'($urandom_range(0, 20000));
				end
			endcase
			case ($urandom_range(7))
				0: lim = '0;
				1: lim = 20'hfffff;
				2, 3, 4, 5: lim = 20'($urandom_range(0, 70000));
				default: lim = 20'($urandom);
			endcase
			case ($urandom_range(7))
				0: thr = '0;
				1: thr = 16'hffff;
				2, 3, 4, 5: thr = 16'($urandom_range(0, 2000));
				default: thr = 16'($urandom);
			endcase
			configure(kp, ki, kd, lo, hi, 1'($urandom), lim, thr);
			if (chunk == 14) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			sp = 16'($urandom);
			fbv = int'(sp) + int'($urandom_range(0, 4000)) - 2000;
			for (int n = 0; n < 75; n++) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					// tracking loop: slowly moving setpoint, measurement walks nearby
					if ($urandom_range(15) == 0)
						sp = 16'($urandom);
					fbv = clip16(fbv + int'($urandom_range(0, 1023)) - 512);
					send_sample(sp, 16'(fbv));
				end else if (pick < 85)
					send_sample(16'($urandom), 16'($urandom));
				else
					send_sample(corner_sample(), corner_sample());
			end
		end

		wait_drain();
		repeat (8) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
hdl/pidaw_pkg.sv
hdl/pid_controller_antiwindup.sv
dv/tb.sv
